[design/rvexbr_pkg.sv]
// ----------------------------------------------------------------------------
// rvexbr_pkg
// Shared types and constants of the RV32I execute and branch unit: operation
// codes and the request and response words.
// ----------------------------------------------------------------------------
package rvexbr_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned OP_W = 6;
	localparam int unsigned SHAMT_W = 5;
	localparam int unsigned SIZE_W = 3;
	localparam logic [XLEN-1:0] INSN_BYTES = XLEN'(4);

	typedef enum logic [OP_W-1:0] {
		OP_LUI = 6'd0, OP_AUIPC, OP_JAL, OP_JALR,
		OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
		OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
		OP_SB, OP_SH, OP_SW,
		OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
		OP_SLLI, OP_SRLI, OP_SRAI,
		OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR,
		OP_SRL, OP_SRA, OP_OR, OP_AND,
		OP_FENCE, OP_ECALL, OP_ILLEGAL
	} op_t;

	localparam logic [SIZE_W-1:0] SIZE_NONE = 3'd0;
	localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
	localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;
	localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]        operation;
		logic [XLEN-1:0]        pc;
		logic signed [XLEN-1:0] immediate;
		logic [XLEN-1:0]        src_a;
		logic [XLEN-1:0]        src_b;
		logic                   predicted_taken;
		logic [XLEN-1:0]        predicted_target;
		logic [XLEN-1:0]        load_raw;
	} exec_req_t;

	typedef struct packed {
		logic [XLEN-1:0]   result_value;
		logic [XLEN-1:0]   mem_address;
		logic [XLEN-1:0]   store_data;
		logic [SIZE_W-1:0] store_size;
		logic              taken;
		logic [XLEN-1:0]   target;
		logic              is_control;
		logic              mispredicted;
		logic              illegal;
	} exec_rsp_t;

endpackage

[design/rvexbr_if.sv]
// ----------------------------------------------------------------------------
// rvexbr_if
// Valid and ready channels that carry request and response words.
// ----------------------------------------------------------------------------
interface rvexbr_req_if import rvexbr_pkg::*; ();
	logic      valid;
	logic      ready;
	exec_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rvexbr_rsp_if import rvexbr_pkg::*; ();
	logic      valid;
	logic      ready;
	exec_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/rvexbr_core.sv]
// ----------------------------------------------------------------------------
// rvexbr_core
// Combinational execute logic: ALU, load extension, address generation and
// branch resolution with misprediction check.
// ----------------------------------------------------------------------------
module rvexbr_core import rvexbr_pkg::*; (
	input  exec_req_t req,
	output exec_rsp_t rsp
);

	logic [XLEN-1:0]    imm;
	logic [XLEN-1:0]    opb;
	logic [XLEN-1:0]    seq_pc;
	logic [XLEN-1:0]    branch_to;
	logic [XLEN-1:0]    ea;
	logic [SHAMT_W-1:0] shamt;
	logic               eq;
	logic               lt_s;
	logic               lt_u;
	logic               use_imm;
	logic               cond;
	logic [XLEN-1:0]    value;
	logic [XLEN-1:0]    addr;
	logic [XLEN-1:0]    sdata;
	logic [SIZE_W-1:0]  ssize;
	logic [XLEN-1:0]    next;
	logic               tk;
	logic               ctrl;
	logic               ill;

	assign imm       = XLEN'(req.immediate);
	assign use_imm   = (req.operation >= OP_ADDI) && (req.operation <= OP_SRAI);
	assign opb       = use_imm ? imm : req.src_b;
	assign seq_pc    = req.pc + INSN_BYTES;
	assign branch_to = req.pc + imm;
	assign ea        = req.src_a + imm;
	assign shamt     = opb[SHAMT_W-1:0];
	assign eq        = (req.src_a == opb);
	assign lt_u      = (req.src_a < opb);
	assign lt_s      = ($signed(req.src_a) < $signed(opb));

	always_comb begin
		value = '0;
		addr  = '0;
		sdata = '0;
		ssize = SIZE_NONE;
		next  = seq_pc;
		tk    = 1'b0;
		ctrl  = 1'b0;
		ill   = 1'b0;
		cond  = 1'b0;
		unique case (req.operation)
			OP_LUI:   value = imm;
			OP_AUIPC: value = branch_to;
			OP_JAL: begin
				value = seq_pc;
				tk    = 1'b1;
				next  = branch_to;
				ctrl  = 1'b1;
			end
			OP_JALR: begin
				value = seq_pc;
				tk    = 1'b1;
				next  = {ea[XLEN-1:1], 1'b0};
				ctrl  = 1'b1;
			end
			OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
				ctrl = 1'b1;
				unique case (req.operation)
					OP_BEQ:  cond = eq;
					OP_BNE:  cond = !eq;
					OP_BLT:  cond = lt_s;
					OP_BGE:  cond = !lt_s;
					OP_BLTU: cond = lt_u;
					default: cond = !lt_u;
				endcase
				tk = cond;
				if (cond) begin
					next = branch_to;
				end
			end
			OP_LB: begin
				addr  = ea;
				value = {{(XLEN-8){req.load_raw[7]}}, req.load_raw[7:0]};
			end
			OP_LH: begin
				addr  = ea;
				value = {{(XLEN-16){req.load_raw[15]}}, req.load_raw[15:0]};
			end
			OP_LW: begin
				addr  = ea;
				value = req.load_raw;
			end
			OP_LBU: begin
				addr  = ea;
				value = {{(XLEN-8){1'b0}}, req.load_raw[7:0]};
			end
			OP_LHU: begin
				addr  = ea;
				value = {{(XLEN-16){1'b0}}, req.load_raw[15:0]};
			end
			OP_SB, OP_SH, OP_SW: begin
				addr  = ea;
				sdata = req.src_b;
				unique case (req.operation)
					OP_SB:   ssize = SIZE_BYTE;
					OP_SH:   ssize = SIZE_HALF;
					default: ssize = SIZE_WORD;
				endcase
			end
			OP_ADDI, OP_ADD:   value = req.src_a + opb;
			OP_SUB:            value = req.src_a - req.src_b;
			OP_SLTI, OP_SLT:   value = {{(XLEN-1){1'b0}}, lt_s};
			OP_SLTIU, OP_SLTU: value = {{(XLEN-1){1'b0}}, lt_u};
			OP_XORI, OP_XOR:   value = req.src_a ^ opb;
			OP_ORI, OP_OR:     value = req.src_a | opb;
			OP_ANDI, OP_AND:   value = req.src_a & opb;
			OP_SLLI, OP_SLL:   value = req.src_a << shamt;
			OP_SRLI, OP_SRL:   value = req.src_a >> shamt;
			OP_SRAI, OP_SRA:   value = XLEN'($signed(req.src_a) >>> shamt);
			OP_FENCE, OP_ECALL: value = '0;
			default:           ill = 1'b1;
		endcase
	end

	always_comb begin
		rsp              = '0;
		rsp.result_value = value;
		rsp.mem_address  = addr;
		rsp.store_data   = sdata;
		rsp.store_size   = ssize;
		rsp.taken        = tk;
		rsp.target       = next;
		rsp.is_control   = ctrl;
		rsp.mispredicted = ctrl && ((req.predicted_taken != tk) ||
			(tk && (req.predicted_target != next)));
		rsp.illegal      = ill;
	end

endmodule

[design/rv32i_execute_branch_unit.sv]
// ----------------------------------------------------------------------------
// rv32i_execute_branch_unit
// Executes one decoded RV32I operation per word and resolves branches.
//
//   channel  direction  word        contents
//   req      in         exec_req_t  operation, operands, prediction, load data
//   rsp      out        exec_rsp_t  result, memory request, resolved branch
//
// One word is taken in every cycle while rsp is not stalled: the input register
// feeds the execute logic, whose outcome is held in the response register.
// Reset clears both stage valid bits only.
// When rsp is stalled the pipeline holds and req stays ready only while the
// input stage is empty.
// ----------------------------------------------------------------------------
module rv32i_execute_branch_unit import rvexbr_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	rvexbr_req_if.sink    req,
	rvexbr_rsp_if.source  rsp
);

	logic      valid_s1;
	logic      valid_s2;
	exec_req_t req_s1;
	exec_rsp_t rsp_s2;
	exec_rsp_t rsp_comb;
	logic      adv_s2;
	logic      adv_s1;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	rvexbr_core u_core (
		.req (req_s1),
		.rsp (rsp_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			req_s1 <= req.data;
		end
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> valid_s1)
		else $error("accepted word did not reach the input stage");

	a_s1_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("input stage word was dropped");

	a_illegal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rsp_s2.illegal) |->
		(!rsp_s2.is_control && (rsp_s2.result_value == '0) &&
		 (rsp_s2.store_size == SIZE_NONE)))
		else $error("illegal operation produced side effects");

	a_noncontrol_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rsp_s2.is_control) |-> (!rsp_s2.taken && !rsp_s2.mispredicted))
		else $error("non-control operation resolved as taken or mispredicted");

	a_store_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (rsp_s2.store_size != SIZE_NONE)) |-> (rsp_s2.result_value == '0))
		else $error("store wrote a destination value");

endmodule

[sim/rv32i_execute_branch_unit_checker.sv]
// ----------------------------------------------------------------------------
// rv32i_execute_branch_unit_checker
// Passive checker for the execute and branch unit. Every request word taken
// by the block is resolved here into the response word it must give. The
// expected words wait in order of arrival, and each response word taken from
// the block is compared field by field with the oldest of them. The number
// of faults and of words still awaited are handed to the testbench top.
// ----------------------------------------------------------------------------
module rv32i_execute_branch_unit_checker import rvexbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rvexbr_req_if       req,
	rvexbr_rsp_if       rsp,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	exec_rsp_t   awaited_rsp[$];
	int unsigned fault_tally = 0;

	function automatic exec_rsp_t resolve_op(input exec_req_t w);
		exec_rsp_t       r;
		logic [XLEN-1:0] imm;
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
		logic [XLEN-1:0] ea;
		logic [XLEN-1:0] branch_to;
		logic            cond;
		imm       = w.immediate;
		a         = w.src_a;
		b         = w.src_b;
		ea        = a + imm;
		branch_to = w.pc + imm;
		cond      = 1'b0;
		r         = '0;
		r.target  = w.pc + INSN_BYTES;
		case (w.operation)
			OP_LUI:   r.result_value = imm;
			OP_AUIPC: r.result_value = w.pc + imm;
			OP_JAL: begin
				r.result_value = w.pc + INSN_BYTES;
				r.taken        = 1'b1;
				r.target       = branch_to;
				r.is_control   = 1'b1;
			end
			OP_JALR: begin
				r.result_value = w.pc + INSN_BYTES;
				r.taken        = 1'b1;
				r.target       = ea & ~XLEN'(1);
				r.is_control   = 1'b1;
			end
			OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
				case (w.operation)
					OP_BEQ:  cond = (a == b);
					OP_BNE:  cond = (a != b);
					OP_BLT:  cond = ($signed(a) < $signed(b));
					OP_BGE:  cond = !($signed(a) < $signed(b));
					OP_BLTU: cond = (a < b);
					default: cond = (a >= b);
				endcase
				r.is_control = 1'b1;
				r.taken      = cond;
				if (cond) begin
					r.target = branch_to;
				end
			end
			OP_LB: begin
				r.mem_address  = ea;
				r.result_value = {{24{w.load_raw[7]}}, w.load_raw[7:0]};
			end
			OP_LH: begin
				r.mem_address  = ea;
				r.result_value = {{16{w.load_raw[15]}}, w.load_raw[15:0]};
			end
			OP_LW: begin
				r.mem_address  = ea;
				r.result_value = w.load_raw;
			end
			OP_LBU: begin
				r.mem_address  = ea;
				r.result_value = {24'b0, w.load_raw[7:0]};
			end
			OP_LHU: begin
				r.mem_address  = ea;
				r.result_value = {16'b0, w.load_raw[15:0]};
			end
			OP_SB, OP_SH, OP_SW: begin
				r.mem_address = ea;
				r.store_data  = b;
				case (w.operation)
					OP_SB:   r.store_size = SIZE_BYTE;
					OP_SH:   r.store_size = SIZE_HALF;
					default: r.store_size = SIZE_WORD;
				endcase
			end
			OP_ADDI:  r.result_value = a + imm;
			OP_SLTI:  r.result_value = XLEN'($signed(a) < $signed(imm));
			OP_SLTIU: r.result_value = XLEN'(a < imm);
			OP_XORI:  r.result_value = a ^ imm;
			OP_ORI:   r.result_value = a | imm;
			OP_ANDI:  r.result_value = a & imm;
			OP_SLLI:  r.result_value = a << imm[SHAMT_W-1:0];
			OP_SRLI:  r.result_value = a >> imm[SHAMT_W-1:0];
			OP_SRAI:  r.result_value = $signed(a) >>> imm[SHAMT_W-1:0];
			OP_ADD:   r.result_value = a + b;
			OP_SUB:   r.result_value = a - b;
			OP_SLL:   r.result_value = a << b[SHAMT_W-1:0];
			OP_SLT:   r.result_value = XLEN'($signed(a) < $signed(b));
			OP_SLTU:  r.result_value = XLEN'(a < b);
			OP_XOR:   r.result_value = a ^ b;
			OP_SRL:   r.result_value = a >> b[SHAMT_W-1:0];
			OP_SRA:   r.result_value = $signed(a) >>> b[SHAMT_W-1:0];
			OP_OR:    r.result_value = a | b;
			OP_AND:   r.result_value = a & b;
			OP_FENCE, OP_ECALL: ;
			default:  r.illegal = 1'b1;
		endcase
		if (r.is_control) begin
			r.mispredicted = (w.predicted_taken != r.taken) ||
				(r.taken && (w.predicted_target != r.target));
		end
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [XLEN-1:0] want,
		input logic [XLEN-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			fault_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		exec_rsp_t want;
		if (!arst_n) begin
			awaited_rsp.delete();
		end else begin
			if (req.valid && req.ready) begin
				awaited_rsp.push_back(resolve_op(req.data));
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited_rsp.size() == 0) begin
					$error("response word taken with none awaited");
					fault_tally++;
				end else begin
					want = awaited_rsp[0];
					awaited_rsp.delete(0);
					compare_field("result_value", want.result_value, rsp.data.result_value);
					compare_field("mem_address", want.mem_address, rsp.data.mem_address);
					compare_field("store_data", want.store_data, rsp.data.store_data);
					compare_field("store_size", XLEN'(want.store_size),
						XLEN'(rsp.data.store_size));
					compare_field("taken", XLEN'(want.taken), XLEN'(rsp.data.taken));
					compare_field("target", want.target, rsp.data.target);
					compare_field("is_control", XLEN'(want.is_control),
						XLEN'(rsp.data.is_control));
					compare_field("mispredicted", XLEN'(want.mispredicted),
						XLEN'(rsp.data.mispredicted));
					compare_field("illegal", XLEN'(want.illegal), XLEN'(rsp.data.illegal));
				end
			end
		end
		mismatches  <= fault_tally;
		outstanding <= awaited_rsp.size();
	end

endmodule

[sim/rv32i_execute_branch_unit_tb.sv]
// ----------------------------------------------------------------------------
// rv32i_execute_branch_unit_tb
// Testbench top for the execute and branch unit. A short directed sequence
// covers the operand extremes, the branch and jump outcomes, load extension,
// store sizes and unknown operation codes, and is followed by random words.
// Words are offered in bursts with random gaps while the response side
// stalls on patterns of its own, once for a long stretch. Checking is done
// by the checker beside the block; this module gives the verdict.
// ----------------------------------------------------------------------------
module rv32i_execute_branch_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rvexbr_pkg::*;

	localparam int unsigned HALF_PERIOD  = 5;
	localparam int unsigned RESET_CYCLES = 10;
	localparam int unsigned RANDOM_WORDS = 1300;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_START   = 300;
	localparam int unsigned HOLD_CYCLES  = 250;
	localparam int unsigned OP_CODE_MAX  = (1 << OP_W) - 1;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_SPARSE,
		STALL_TOGGLE
	} stall_mode_e;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned burst_left = 0;

	rvexbr_req_if req_if ();
	rvexbr_rsp_if rsp_if ();

	rv32i_execute_branch_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	rv32i_execute_branch_unit_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.rsp         (rsp_if),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic exec_req_t make_word(input logic [OP_W-1:0] op,
		input logic [XLEN-1:0] pc, input logic [XLEN-1:0] imm,
		input logic [XLEN-1:0] a, input logic [XLEN-1:0] b,
		input logic pt, input logic [XLEN-1:0] ptarget, input logic [XLEN-1:0] raw);
		exec_req_t w;
		w.operation        = op;
		w.pc               = pc;
		w.immediate        = imm;
		w.src_a            = a;
		w.src_b            = b;
		w.predicted_taken  = pt;
		w.predicted_target = ptarget;
		w.load_raw         = raw;
		return w;
	endfunction

	function automatic exec_req_t random_word();
		exec_req_t       w;
		logic [XLEN-1:0] bits;
		logic [XLEN-1:0] guess;
		bits = $urandom;
		case ($urandom_range(0, 9))
			0, 1:    w.operation = OP_W'($urandom_range(OP_JAL, OP_BGEU));
			2:       w.operation = OP_W'($urandom_range(int'(OP_ILLEGAL) + 1, OP_CODE_MAX));
			default: w.operation = OP_W'($urandom_range(OP_LUI, OP_ILLEGAL));
		endcase
		w.pc = $urandom;
		if ($urandom_range(0, 7) == 0) begin
			w.pc[XLEN-1:8] = '1;
		end
		case ($urandom_range(0, 3))
			0, 1:    w.immediate = {{20{bits[11]}}, bits[11:0]};
			2:       w.immediate = {bits[31:12], 12'b0};
			default: w.immediate = bits;
		endcase
		w.src_a = $urandom;
		case ($urandom_range(0, 3))
			0:       w.src_b = w.src_a;
			1:       w.src_b = $urandom_range(0, 64);
			default: w.src_b = $urandom;
		endcase
		w.predicted_taken = 1'($urandom_range(0, 1));
		if (w.operation == OP_JALR) begin
			guess = (w.src_a + w.immediate) & ~XLEN'(1);
		end else begin
			guess = w.pc + w.immediate;
		end
		w.predicted_target = $urandom_range(0, 1) ? guess : $urandom;
		w.load_raw = $urandom;
		return w;
	endfunction

	task automatic offer(input exec_req_t w);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if ($urandom_range(0, 3) != 0) begin
				req_if.valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.data  <= w;
		do @(posedge clk); while (!req_if.ready);
	endtask

	initial begin
		exec_req_t directed[$];
		arst_n       <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_word(OP_LUI, 32'h0000_1000, 32'h8000_0000, '1, '1, 1'b1, '1, '1));
		directed.push_back(make_word(OP_AUIPC, 32'hffff_fffc, 32'd8, '0, '0, 1'b0, '0, '0));
		directed.push_back(make_word(OP_JAL, 32'h0000_1000, -32'sd8, '0, '0, 1'b1,
			32'h0000_0ff8, '0));
		directed.push_back(make_word(OP_JAL, 32'hffff_fffc, 32'd16, '0, '0, 1'b0,
			32'h0000_000c, '0));
		directed.push_back(make_word(OP_JALR, 32'h0000_4000, 32'd2, 32'h0000_2001, '0, 1'b1,
			32'h0000_2002, '0));
		directed.push_back(make_word(OP_JALR, 32'h0000_4000, -32'sd1, 32'h0000_2000, '0, 1'b1,
			32'h0000_2000, '0));
		directed.push_back(make_word(OP_BEQ, 32'h0000_0100, 32'h0000_0040, '1, '1, 1'b1,
			32'h0000_0140, '0));
		directed.push_back(make_word(OP_BNE, 32'h0000_0100, 32'h0000_0040, 32'd5, 32'd5, 1'b1,
			32'h0000_0140, '0));
		directed.push_back(make_word(OP_BLT, 32'h0000_0200, -32'sd4, 32'h8000_0000,
			32'h7fff_ffff, 1'b1, 32'h0000_0000, '0));
		directed.push_back(make_word(OP_BGE, 32'h0000_0200, 32'h0000_0800, 32'h8000_0000,
			32'h8000_0000, 1'b1, 32'h0000_0a00, '0));
		directed.push_back(make_word(OP_BLTU, 32'h0000_0300, 32'h0000_0010, '0, '1, 1'b0,
			32'h0000_0310, '0));
		directed.push_back(make_word(OP_BGEU, 32'h0000_0300, 32'h0000_0010, '0, 32'd1, 1'b0,
			32'h1234_5678, '0));
		directed.push_back(make_word(OP_LB, '0, 32'd4, 32'h0000_1000, '0, 1'b0, '0,
			32'h0000_0080));
		directed.push_back(make_word(OP_LH, '0, -32'sd2, 32'h0000_1000, '0, 1'b0, '0,
			32'h1234_8000));
		directed.push_back(make_word(OP_LW, '0, 32'd2, '1, '0, 1'b0, '0, 32'hdead_beef));
		directed.push_back(make_word(OP_LBU, '0, '0, 32'h0000_2000, '0, 1'b0, '0, '1));
		directed.push_back(make_word(OP_LHU, '0, 32'h7fff_ffff, 32'h8000_0001, '0, 1'b0, '0, '1));
		directed.push_back(make_word(OP_SB, '0, -32'sd4, 32'h0000_0100, 32'hcafe_f00d, 1'b0,
			'0, '0));
		directed.push_back(make_word(OP_SH, '0, -32'sd4, 32'h0000_0100, '1, 1'b0, '0, '0));
		directed.push_back(make_word(OP_SW, '0, 32'h8000_0000, 32'h8000_0000, 32'hcafe_f00d,
			1'b0, '0, '0));
		directed.push_back(make_word(OP_SRAI, '0, '1, 32'h8000_0000, '0, 1'b0, '0, '0));
		directed.push_back(make_word(OP_SRA, '0, '0, 32'h8000_0001, 32'hffff_ffe1, 1'b0, '0, '0));
		directed.push_back(make_word(OP_FENCE, 32'h0000_0500, '1, '1, '1, 1'b1, '1, '1));
		directed.push_back(make_word(OP_ECALL, 32'hffff_fffc, '1, '1, '1, 1'b1, '1, '1));
		directed.push_back(make_word(OP_ILLEGAL, 32'h0000_0600, '1, '1, '1, 1'b1, '1, '1));
		directed.push_back(make_word(OP_W'(OP_CODE_MAX), 32'hffff_fffc, '1, '1, '1, 1'b1, '1,
			'1));

		foreach (directed[i]) begin
			offer(directed[i]);
		end
		repeat (RANDOM_WORDS) begin
			offer(random_word());
		end
		req_if.valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		stall_mode_e mode;
		int unsigned cycle;
		logic        held;
		cycle = 0;
		held  = 1'b0;
		rsp_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!held && cycle >= HOLD_START) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				cycle += HOLD_CYCLES;
				held = 1'b1;
			end
			mode = stall_mode_e'($urandom_range(0, 3));
			repeat ($urandom_range(8, 60)) begin
				case (mode)
					STALL_NONE:   rsp_if.ready <= 1'b1;
					STALL_RANDOM: rsp_if.ready <= 1'($urandom_range(0, 1));
					STALL_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
					default:      rsp_if.ready <= !rsp_if.ready;
				endcase
				@(posedge clk);
				cycle++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
